// File: hw/rtl/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg
// shared types and state codes for the dominance bipartite matcher
// ----------------------------------------------------------------------------
package dbm_pkg;

  typedef struct packed {
    logic signed [31:0] left_first;
    logic signed [31:0] left_second;
    logic signed [31:0] right_first;
    logic signed [31:0] right_second;
    logic               last_item;
  } dbm_in_t;

  typedef struct packed {
    logic [7:0] matched_count;
    logic       all_matched;
    logic       overflow;
  } dbm_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_ROOT,
    ST_FETCH,
    ST_SCAN,
    ST_FLIP_RD,
    ST_FLIP,
    ST_POP,
    ST_DONE
  } dbm_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // store the input word
    logic clr_start;   // reset sweep index
    logic clr_step;    // clear one partner entry
    logic root_init;   // begin root at u_q
    logic next_root;   // advance root index
    logic fetch;       // restart compare for the loaded top frame
    logic scan_step;   // evaluate candidate, advance
    logic flip_rd;     // read frame for flip
    logic flip_wr;     // write partners for frame
    logic pop;         // drop frame
    logic found_inc;   // count augmentation
    logic finish;      // clear set counters
  } dbm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic roots_done;   // root index reached item count
    logic root_matched; // current root already has a partner
    logic scan_hit_free;
    logic scan_hit_push;
    logic scan_end;     // candidate index reached item count
    logic flip_last;    // flipping bottom frame
    logic stack_empty_after_pop;
  } dbm_sts_t;

endpackage

// File: hw/rtl/dbm_datapath.sv
// ----------------------------------------------------------------------------
// dbm_datapath
// item stores, partner tables, visited marks, search stack and counters
// ----------------------------------------------------------------------------
module dbm_datapath import dbm_pkg::*; #(
  parameter int MAX_ITEMS = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dbm_in_t  in_word_i,
  input  dbm_cmd_t cmd_i,
  output dbm_sts_t sts_o,
  output dbm_out_t res_o
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // item stores, one write port, one registered read each
  logic [31:0] lf_mem [MAX_ITEMS];
  logic [31:0] ls_mem [MAX_ITEMS];
  logic [31:0] rf_mem [MAX_ITEMS];
  logic [31:0] rs_mem [MAX_ITEMS];
  // partner tables
  logic [IW:0] rp_mem [MAX_ITEMS];  // msb is valid
  logic [IW:0] lp_mem [MAX_ITEMS];
  // visited marks hold the root that visited, msb is valid
  logic [IW:0] vis_mem [MAX_ITEMS];
  // stack frames
  logic [IW-1:0] stk_node [MAX_ITEMS];
  logic [IW-1:0] stk_next [MAX_ITEMS];

  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic [CW-1:0] u_q;
  logic [CW-1:0] found_q;
  logic [CW-1:0] depth_q;    // frames on stack
  logic [IW-1:0] node_q;     // top frame left node
  logic [CW-1:0] j_q;        // candidate
  logic [CW-1:0] clr_q;
  logic [CW-1:0] k_q;        // flip frame index
  logic [31:0]   lf_q, ls_q, rf_q, rs_q;
  logic [IW:0]   rp_q;
  logic [IW:0]   vis_rd_q;
  logic          cmp_ok_q;   // read data valid for j_q
  logic [IW-1:0] fl_node_q, fl_next_q;
  logic [IW-1:0] par_node_q, par_next_q;  // frame below the top

  logic [IW-1:0] j_ix, top_ix, par_ix;
  assign j_ix   = j_q[IW-1:0];
  assign top_ix = CW'(depth_q - 1'b1) == '0 ? '0 : IW'(depth_q - 1'b1);
  assign par_ix = IW'(depth_q - CW'(2));

  logic joined;
  assign joined = (lf_q > rs_q) && (ls_q >= rf_q);

  logic visited;
  assign visited = (vis_rd_q == {1'b1, u_q[IW-1:0]});

  // stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < CW'(MAX_ITEMS)) begin
      lf_mem[count_q[IW-1:0]] <= in_word_i.left_first   ^ 32'h8000_0000;
      ls_mem[count_q[IW-1:0]] <= in_word_i.left_second  ^ 32'h8000_0000;
      rf_mem[count_q[IW-1:0]] <= in_word_i.right_first  ^ 32'h8000_0000;
      rs_mem[count_q[IW-1:0]] <= in_word_i.right_second ^ 32'h8000_0000;
    end
    lf_q <= lf_mem[node_q];
    ls_q <= ls_mem[node_q];
    rf_q <= rf_mem[j_ix];
    rs_q <= rs_mem[j_ix];
    rp_q <= rp_mem[j_ix];
  end

  // partner tables as memories with one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      rp_mem[clr_q[IW-1:0]] <= '0;
      lp_mem[clr_q[IW-1:0]] <= '0;
    end else if (cmd_i.flip_wr) begin
      rp_mem[fl_next_q] <= {1'b1, fl_node_q};
      lp_mem[fl_node_q] <= {1'b1, fl_next_q};
    end
  end

  // visited marks, cleared by the sweep, tagged with the root
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      vis_mem[clr_q[IW-1:0]] <= '0;
    end else if (cmd_i.scan_step && (sts_o.scan_hit_push || sts_o.scan_hit_free)) begin
      vis_mem[j_ix] <= {1'b1, u_q[IW-1:0]};
    end
    vis_rd_q <= vis_mem[j_ix];
  end

  // left partner valid lookup for root skip, registered read
  logic lp_valid_q;
  always_ff @(posedge clk_i) lp_valid_q <= lp_mem[u_q[IW-1:0]][IW];

  // stack, registered reads for flip and for the parent frame
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      stk_node[0] <= u_q[IW-1:0];
    end else if (cmd_i.scan_step && sts_o.scan_hit_push) begin
      stk_node[depth_q[IW-1:0]] <= rp_q[IW-1:0];
    end
    if (cmd_i.scan_step && (sts_o.scan_hit_push || sts_o.scan_hit_free)) begin
      stk_next[top_ix] <= j_ix;
    end
    if (cmd_i.flip_rd) begin
      fl_node_q <= stk_node[k_q[IW-1:0]];
      fl_next_q <= stk_next[k_q[IW-1:0]];
    end
    par_node_q <= stk_node[par_ix];
    par_next_q <= stk_next[par_ix];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      u_q      <= '0;
      found_q  <= '0;
      depth_q  <= '0;
      node_q   <= '0;
      j_q      <= '0;
      clr_q    <= '0;
      k_q      <= '0;
      cmp_ok_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (count_q < CW'(MAX_ITEMS)) count_q <= count_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      if (cmd_i.clr_start) begin
        clr_q   <= '0;
        u_q     <= '0;
        found_q <= '0;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.next_root) u_q <= u_q + 1'b1;
      if (cmd_i.found_inc) found_q <= found_q + 1'b1;
      if (cmd_i.root_init) begin
        depth_q <= CW'(1);
        node_q  <= u_q[IW-1:0];
        j_q     <= '0;
      end
      if (cmd_i.fetch) begin
        cmp_ok_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (!cmp_ok_q) begin
          cmp_ok_q <= 1'b1;
        end else if (sts_o.scan_hit_push) begin
          depth_q <= depth_q + 1'b1;
          node_q  <= rp_q[IW-1:0];
          j_q     <= '0;
        end else if (sts_o.scan_hit_free) begin
          k_q <= depth_q - 1'b1;
        end else begin
          j_q      <= j_q + 1'b1;
          cmp_ok_q <= 1'b0;
        end
      end
      if (cmd_i.flip_wr) k_q <= k_q - 1'b1;
      // parent resumes at the candidate after the one it pushed
      if (cmd_i.pop) begin
        depth_q <= depth_q - 1'b1;
        if (depth_q > CW'(1)) begin
          node_q <= par_node_q;
          j_q    <= CW'(par_next_q) + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  logic cand;
  assign cand = cmp_ok_q && (j_q < count_q) && !visited && joined;

  always_comb begin
    sts_o.clr_done      = (clr_q == CW'(MAX_ITEMS - 1));
    sts_o.roots_done    = (u_q >= count_q);
    sts_o.root_matched  = lp_valid_q;
    sts_o.scan_hit_free = cand && !rp_q[IW];
    sts_o.scan_hit_push = cand && rp_q[IW] && (depth_q < CW'(MAX_ITEMS));
    sts_o.scan_end      = (j_q >= count_q);
    sts_o.flip_last     = (k_q == '0);
    sts_o.stack_empty_after_pop = (depth_q == CW'(1));
  end

  always_comb begin
    res_o.matched_count = 8'(found_q);
    res_o.all_matched   = (found_q == count_q);
    res_o.overflow      = ovf_q;
  end

endmodule

// File: hw/rtl/dbm_ctrl.sv
// ----------------------------------------------------------------------------
// dbm_ctrl
// sequencer for loading, table clear, root loop and depth-first search
// ----------------------------------------------------------------------------
module dbm_ctrl import dbm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output logic     res_cap_o,
  input  dbm_sts_t sts_i,
  output dbm_cmd_t cmd_o
);

  dbm_state_e state_q, state_d;
  logic       rwait_q, rwait_d;   // wait for the registered partner read at root
  logic       ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      rwait_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rwait_q <= rwait_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    rwait_d    = 1'b0;
    ov_d       = ov_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    res_cap_o  = 1'b0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.clr_start = 1'b1;
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (sts_i.roots_done) begin
          state_d = ST_DONE;
        end else if (!rwait_q) begin
          rwait_d = 1'b1;
        end else if (sts_i.root_matched) begin
          cmd_o.next_root = 1'b1;
        end else begin
          cmd_o.root_init = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = ST_POP;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_hit_free) state_d = ST_FLIP_RD;
          else if (sts_i.scan_hit_push) state_d = ST_FETCH;
        end
      end
      ST_FLIP_RD: begin
        cmd_o.flip_rd = 1'b1;
        state_d = ST_FLIP;
      end
      ST_FLIP: begin
        cmd_o.flip_wr = 1'b1;
        if (sts_i.flip_last) begin
          cmd_o.found_inc = 1'b1;
          cmd_o.next_root = 1'b1;
          state_d = ST_ROOT;
        end else begin
          state_d = ST_FLIP_RD;
        end
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        if (sts_i.stack_empty_after_pop) begin
          cmd_o.next_root = 1'b1;
          state_d = ST_ROOT;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!ov_q || !out_stall_i) begin
          res_cap_o    = 1'b1;
          cmd_o.finish = 1'b1;
          ov_d         = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

// File: hw/rtl/dominance_bipartite_matcher_top.sv
// ----------------------------------------------------------------------------
// dominance_bipartite_matcher_top
// maximum bipartite matching over loaded item pairs with dominance edges
// ----------------------------------------------------------------------------
// one input word is stored per cycle while loading. the word with last_item
// set closes the set: a clear sweep resets the partner tables and visited
// marks, then an augmenting-path search runs root by root, testing right
// candidates one at a time against the stores (one registered read port
// each), with an explicit stack. the search time after the last word is
// data dependent. no input word is taken during the search. one result
// word is then held on the output register until taken; the next set may
// start loading meanwhile.
module dominance_bipartite_matcher_top import dbm_pkg::*; #(
  parameter int MAX_ITEMS = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dbm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dbm_out_t out_data_o
);

  dbm_cmd_t cmd;
  dbm_sts_t sts;
  dbm_out_t res;
  logic     res_cap;

  // sequencer
  dbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_item),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_cap_o   (res_cap),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stores, tables and search state
  dbm_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (res)
  );

  // output word register
  dbm_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (res_cap) out_q <= res;
  end
  assign out_data_o = out_q;

  // a result is only captured while none is pending or being taken
  a_cap_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cap |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten");

  // a new result is presented right after capture
  a_cap_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cap |=> out_valid_o)
    else $error("captured result not presented");

  // no load happens while the search runs
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !(cmd.scan_step || cmd.flip_wr || cmd.clr_step))
    else $error("load during search");

endmodule

// File: test/dominance_bipartite_matcher_top_tb.sv
// ----------------------------------------------------------------------------
// dominance_bipartite_matcher_top_tb
// self-checking bench for the dominance bipartite matcher
// ----------------------------------------------------------------------------
// words are sent as sets closed by last_item. a behavioral matcher predicts
// the size of the maximum matching for every closed set, and a monitor
// compares each result word with the oldest prediction. both sides idle and
// stall at random in several phases.
`timescale 1ns / 1ps

module dominance_bipartite_matcher_top_tb;
  import dbm_pkg::*;

  localparam int MAX_ITEMS = 128;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  dbm_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  dbm_out_t out_data_o;

  dominance_bipartite_matcher_top #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // idle percentages for the current phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned words_sent;

  // predictor state: the current set as signed values, capped like the block's stores
  int  set_lf[MAX_ITEMS];
  int  set_ls[MAX_ITEMS];
  int  set_rf[MAX_ITEMS];
  int  set_rs[MAX_ITEMS];
  int  set_size;
  bit  set_overflow;
  // matcher scratch
  bit  right_seen[MAX_ITEMS];
  int  right_owner[MAX_ITEMS];

  dbm_out_t expected_results[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver stall pattern, changes on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // edge test, signed on both comparisons
  function automatic bit joined(int l, int r);
    return set_lf[l] > set_rs[r] && set_ls[l] >= set_rf[r];
  endfunction

  // augmenting path search from left node u
  function automatic bit augment_path(int u);
    for (int j = 0; j < set_size; j++) begin
      if (!right_seen[j] && joined(u, j)) begin
        right_seen[j] = 1'b1;
        if (right_owner[j] < 0 || augment_path(right_owner[j])) begin
          right_owner[j] = u;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // fold one accepted word into the predicted set
  task automatic predict_word(input dbm_in_t w);
    int found;
    dbm_out_t res;
    found = 0;
    if (set_size < MAX_ITEMS) begin
      set_lf[set_size] = int'(w.left_first);
      set_ls[set_size] = int'(w.left_second);
      set_rf[set_size] = int'(w.right_first);
      set_rs[set_size] = int'(w.right_second);
      set_size++;
    end else begin
      set_overflow = 1'b1;
    end
    if (w.last_item) begin
      for (int j = 0; j < MAX_ITEMS; j++) right_owner[j] = -1;
      for (int u = 0; u < set_size; u++) begin
        for (int j = 0; j < MAX_ITEMS; j++) right_seen[j] = 1'b0;
        if (augment_path(u)) found++;
      end
      res.matched_count = found[7:0];
      res.all_matched   = (found == set_size);
      res.overflow      = set_overflow;
      expected_results = {expected_results, res};
      set_size     = 0;
      set_overflow = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    dbm_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.matched_count !== want.matched_count)
          report_mismatch("matched_count", out_data_o.matched_count, want.matched_count);
        if (out_data_o.all_matched !== want.all_matched)
          report_mismatch("all_matched", out_data_o.all_matched, want.all_matched);
        if (out_data_o.overflow !== want.overflow)
          report_mismatch("overflow", out_data_o.overflow, want.overflow);
      end
    end
  end

  // send one word; driven on the falling edge, held until taken.
  // valid stays high into the next call so back to back words need no gap
  task automatic send_word(input dbm_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  // mostly small values so edges are dense and ties are common
  function automatic int pick_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return int'($urandom_range(16)) - 8;
    endcase
  endfunction

  function automatic dbm_in_t make_word(int lf, int ls, int rf, int rs, bit last);
    dbm_in_t w;
    w.left_first   = lf;
    w.left_second  = ls;
    w.right_first  = rf;
    w.right_second = rs;
    w.last_item    = last;
    return w;
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++)
      send_word(make_word(pick_value(), pick_value(), pick_value(), pick_value(),
                          i == n - 1));
  endtask

  // field extremes and the strict / non-strict boundaries of the edge test
  task automatic test_edge_boundaries();
    // single node, strict compare fails on equal values
    send_word(make_word(5, 5, 5, 5, 1'b1));
    // single node, strict passes and the second test passes on a tie
    send_word(make_word(6, 5, 5, 5, 1'b1));
    // extremes: max vs min both ways
    send_word(make_word(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1));
    send_word(make_word(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1));
    send_word(make_word(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b1));
    // negative vs positive must compare signed
    send_word(make_word(-1, -1, 0, -2, 1'b1));
    send_word(make_word(1, 0, 32'h80000000, 0, 1'b1));
    // set needing an augmenting path: greedy first choice must be undone
    send_word(make_word(10, 10, 0, 0, 1'b0));
    send_word(make_word(5, 5, 0, 0, 1'b0));
    send_word(make_word(1, 1, 20, 20, 1'b1));
    // three nodes, chain of reassignment
    send_word(make_word(3, 3, 0, 0, 1'b0));
    send_word(make_word(3, 3, 0, 2, 1'b0));
    send_word(make_word(1, 1, 0, 0, 1'b1));
    // all bits toggled in every field
    send_word(make_word(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 1'b0));
    send_word(make_word(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 1'b1));
  endtask

  // full stores: exactly full, then words beyond capacity
  task automatic test_capacity();
    send_random_set(MAX_ITEMS);
    send_random_set(MAX_ITEMS + 3);
    // full set whose last word alone spills over
    send_random_set(MAX_ITEMS + 1);
  endtask

  task automatic test_random_sets(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned word_target);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = words_sent;
    while (words_sent - start < word_target) begin
      if ($urandom_range(99) < 4) send_random_set($urandom_range(20, 64));
      else send_random_set($urandom_range(1, 10));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    words_sent     = 0;
    set_size       = 0;
    set_overflow   = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_edge_boundaries();
    test_capacity();
    // idle phases: none, sender idle, receiver stalling, both
    test_random_sets(0, 0, 210);
    test_random_sets(80, 0, 210);
    test_random_sets(0, 80, 210);
    test_random_sets(14, 14, 210);
    // no idling or stalling at the tail, and valid drops
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
